/* rtl/smat_pkg.sv */
package smat_pkg;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int SIZE_W     = 40;
    localparam int ADDR_W     = 64;
    localparam int USERS_W    = 6;
    localparam int IN_DATA_W  = SIZE_W + ADDR_W;   // 104 bits, 13 bytes
    localparam int OUT_DATA_W = ADDR_W + SIZE_W;   // 104 bits, 13 bytes

    // Significant bits of a size key
    localparam int SIZE_BITS  = SIZE_W;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 40;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ALIAS_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEAF_SIZE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_USER_LIMIT   = 2'd2;

    // Reset values and limits
    localparam logic [SIZE_W-1:0]  LEAF_SIZE_RESET = 40'd2097152;
    localparam logic [USERS_W-1:0] DEFAULT_LIMIT   = 6'd8;
    localparam logic [USERS_W-1:0] MAX_LIMIT       = 6'd32;

    // One table entry
    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [ADDR_W-1:0]  addr;
        logic [USERS_W-1:0] users;
        logic [USERS_W-1:0] limit;
    } t_entry;

    // Configuration registers
    typedef struct packed {
        logic               enable;
        logic [SIZE_W-1:0]  leaf_size;
        logic [USERS_W-1:0] user_limit;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic               aliased;
        logic [ADDR_W-1:0]  alias_addr;
        logic [SIZE_W-1:0]  map_size;
    } t_result;

endpackage

/* rtl/smat_mem.sv */
module smat_mem
    import smat_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/smat_ctrl.sv */
module smat_ctrl
    import smat_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int IDX_W         = 6,
    parameter int CNT_W         = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    // item in
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [ADDR_W-1:0] i_addr,
    // result out
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    // table memory
    output logic              o_mem_we,
    output logic [IDX_W-1:0]  o_mem_waddr,
    output t_entry            o_mem_wdata,
    output logic [IDX_W-1:0]  o_mem_raddr,
    input  t_entry            i_mem_rdata
);

    localparam logic [SIZE_W:0] KEY_ONES = (SIZE_W + 1)'(1) << SIZE_BITS;
    localparam logic [SIZE_W-1:0] KEY_MASK =
        (SIZE_BITS >= SIZE_W) ? {SIZE_W{1'b1}} : SIZE_W'(KEY_ONES - (SIZE_W + 1)'(1));
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [SIZE_W-1:0]   r_key, n_key;
    logic                r_hit, n_hit;
    logic [ADDR_W-1:0]   r_alias, n_alias;

    logic [SIZE_W-1:0]   key;
    logic [SIZE_W-1:0]   leaf;
    logic [USERS_W-1:0]  new_limit;
    logic [CNT_W-1:0]    idx_next;
    logic                entry_match;
    logic                accept;

    assign key       = i_size & KEY_MASK;
    assign leaf      = i_cfg.leaf_size & KEY_MASK;
    assign accept    = i_valid && (r_state == S_IDLE);
    assign idx_next  = CNT_W'(r_idx) + CNT_W'(1);
    assign new_limit = (i_cfg.user_limit == '0 || i_cfg.user_limit > MAX_LIMIT)
                       ? DEFAULT_LIMIT : i_cfg.user_limit;
    assign entry_match = (i_mem_rdata.size == r_key) &&
                         (i_mem_rdata.users < i_mem_rdata.limit);

    // Sequencer: decode, scan one entry per cycle, hold result
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_key       = r_key;
        n_hit       = r_hit;
        n_alias     = r_alias;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_hit   = 1'b0;
                    n_key   = key;
                    n_idx   = '0;
                    n_state = S_DONE;
                    unique case (i_cmd)
                        CMD_LOOKUP: begin
                            if (i_cfg.enable && key != '0 && key <= leaf && r_used != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_REGISTER: begin
                            if (i_cfg.enable && key != '0 && r_used < FULL_COUNT) begin
                                o_mem_we          = 1'b1;
                                o_mem_waddr       = r_used[IDX_W-1:0];
                                o_mem_wdata.size  = key;
                                o_mem_wdata.addr  = i_addr;
                                o_mem_wdata.users = USERS_W'(1);
                                o_mem_wdata.limit = new_limit;
                                n_used            = r_used + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            n_used = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (entry_match) begin
                    // claim one more user, write back in place
                    o_mem_we          = 1'b1;
                    o_mem_waddr       = r_idx;
                    o_mem_wdata.users = i_mem_rdata.users + USERS_W'(1);
                    n_hit             = 1'b1;
                    n_alias           = i_mem_rdata.addr;
                    n_state           = S_DONE;
                end else if (idx_next < r_used) begin
                    o_mem_raddr = idx_next[IDX_W-1:0];
                    n_idx       = idx_next[IDX_W-1:0];
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
        r_idx   <= n_idx;
        r_key   <= n_key;
        r_hit   <= n_hit;
        r_alias <= n_alias;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_res_valid      = (r_state == S_DONE);
    assign o_res.aliased    = r_hit;
    assign o_res.alias_addr = r_hit ? r_alias : '0;
    assign o_res.map_size   = r_hit ? r_key : '0;

endmodule

/* rtl/shared_mapping_alias_table.sv */
// Table of up to TABLE_ENTRIES shared mappings kept in a single-port-read RAM.
// A lookup reads the registered entries in order until the first hit or the
// end of the table, scanning one entry per cycle through the RAM's registered
// read port. Register, clear and unused commands go straight to the result
// with no scan, as does a lookup that fails the enable, size or leaf checks or
// finds an empty table. One item is in work at a time; the result sits in an
// output register so the next item can be taken while it waits.
// Configuration writes are always accepted and must only be issued while idle.
module shared_mapping_alias_table
    import smat_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,   // [39:0] size_bytes, [103:40] base_addr
    input  logic [CMD_W-1:0]       i_s_axis_tuser,   // [1:0] command
    // result items
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,   // [63:0] alias_addr, [103:64] map_size
    output logic                   o_m_axis_tuser,   // [0] aliased
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    t_cfg     r_cfg;
    t_result  res;
    logic     res_valid;
    logic     res_ready;
    logic     r_out_valid;
    t_result  r_out;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    t_entry             mem_rdata;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= 1'b0;
            r_cfg.leaf_size  <= LEAF_SIZE_RESET;
            r_cfg.user_limit <= DEFAULT_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ALIAS_ENABLE: r_cfg.enable     <= i_cfg_data[0];
                REG_LEAF_SIZE:    r_cfg.leaf_size  <= i_cfg_data[SIZE_W-1:0];
                REG_USER_LIMIT:   r_cfg.user_limit <= i_cfg_data[USERS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    smat_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_cmd       (i_s_axis_tuser),
        .i_size      (i_s_axis_tdata[SIZE_W-1:0]),
        .i_addr      (i_s_axis_tdata[SIZE_W +: ADDR_W]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    smat_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.map_size, r_out.alias_addr};
    assign o_m_axis_tuser  = r_out.aliased;

endmodule
